>>> rtl/sapwm_pkg.sv
// ----------------------------------------------------------------------------
// sapwm_pkg
// Shared constants, register indexes and the calibration bundle of the servo
// angle to PWM count mapper.
// ----------------------------------------------------------------------------
package sapwm_pkg;

   localparam int ANGLE_FRAC_BITS = 4;
   localparam int ANGLE_W         = 16;
   localparam int COUNT_W         = 13;
   localparam int U_W             = 12;
   localparam int M_W             = 13;
   localparam int ADDR_W          = 4;
   localparam int DATA_W          = 32;

   localparam logic [COUNT_W-1:0] PWM_FULL = COUNT_W'(4096);

   localparam logic [U_W-1:0] U_HALF = U_W'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [U_W-1:0] U_SPAN = U_W'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [M_W-1:0] M_BASE = M_W'(270 * (2 ** ANGLE_FRAC_BITS));

   localparam int COEF_SHIFT = 2 * ANGLE_FRAC_BITS;
   localparam int E_SHIFT    = 3 * ANGLE_FRAC_BITS;
   localparam int X_LSB      = 5;

   localparam logic [16:0] DIV_BASE = 17'd91125;
   localparam logic [31:0] RECIP_M  = 32'((64'd1 << 48) / 64'd91125);

   localparam logic signed [18:0] BIAS_STEPS = 19'sd16384;
   localparam logic signed [38:0] SUM_BIAS   =
      39'(64'd1458000 + 64'd16384 * 64'd2916000);

   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_CNT_M90  = 2'd1;
   localparam logic [1:0] REG_CNT_ZERO = 2'd2;
   localparam logic [1:0] REG_CNT_P90  = 2'd3;

   typedef struct packed {
      logic               three_point;
      logic [COUNT_W-1:0] y0;
      logic [COUNT_W-1:0] y1;
      logic [COUNT_W-1:0] y2;
   } sapwm_cfg_type;

endpackage

>>> rtl/sapwm_pipe.sv
// ----------------------------------------------------------------------------
// sapwm_pipe
// Ten-stage datapath: angle clamp, spline coefficients, Horner products,
// scaling by the constant denominator, rounding and saturation.
// ----------------------------------------------------------------------------
module sapwm_pipe (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sapwm_pkg::sapwm_cfg_type               cfg,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  logic signed [sapwm_pkg::ANGLE_W-1:0]   in_angle,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output logic        [sapwm_pkg::COUNT_W-1:0]   out_count
);
   import sapwm_pkg::*;

   localparam int NST = 10;
   localparam logic signed [14:0] C8100 = 15'sd8100;
   localparam logic signed [16:0] ANGLE_OFFSET = 17'(U_HALF);
   localparam logic signed [16:0] ANGLE_MAX    = 17'(U_SPAN);

   typedef enum logic [1:0] {PIECE_LINE, PIECE_LEFT, PIECE_RIGHT} piece_type;

   logic [NST:1] vld_ff;
   logic [NST:1] adv;

   logic [U_W-1:0]         t1_ff, t1_in, t2_ff, t3_ff, t4_ff, t5_ff;
   logic [M_W-1:0]         m1_ff, m1_in, m2_ff;
   piece_type              pc1_ff, pc1_in;
   logic [COUNT_W-1:0]     base2_ff, base2_in, base3_ff, base4_ff, base5_ff;
   logic [COUNT_W-1:0]     base6_ff, base7_ff, base8_ff, base9_ff;
   logic signed [13:0]     s2_ff, s2_in;
   logic signed [15:0]     e2_ff, e2_in;
   logic signed [25:0]     p3_ff, p3_in;
   logic signed [28:0]     c3_ff, c3_in, c4_ff;
   logic signed [36:0]     q4_ff, q4_in;
   logic signed [37:0]     r5_ff, r5_in;
   logic signed [49:0]     e6_ff, e6_in;
   logic [31:0]            x7_ff, x7_in, x8_ff;
   logic [15:0]            q8_ff, q8_in, q9_ff;
   logic [17:0]            rem9_ff, rem9_in;
   logic [COUNT_W-1:0]     cnt10_ff, cnt10_in;

   logic signed [16:0]     sum1;
   logic [U_W-1:0]         u1;
   logic signed [17:0]     sfull, dsel, e18;
   logic signed [27:0]     p_full;
   logic signed [30:0]     c_full;
   logic signed [38:0]     q_full;
   logic signed [37:0]     c_ext, q_ext;
   logic signed [50:0]     e_full;
   logic signed [38:0]     sum7;
   logic [63:0]            prod8;
   logic [32:0]            back9;
   logic [16:0]            qz;
   logic signed [18:0]     z10;

   always_comb begin
      adv[NST] = !vld_ff[NST] || !out_stall;
      for (int i = NST - 1; i >= 1; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign in_stall  = !adv[1];
   assign out_valid = vld_ff[NST];
   assign out_count = cnt10_ff;

   // clamp angle, pick piece
   always_comb begin
      sum1 = {in_angle[ANGLE_W-1], in_angle} + ANGLE_OFFSET;
      if (sum1 < 0) begin
         u1 = '0;
      end else if (sum1 > ANGLE_MAX) begin
         u1 = U_SPAN;
      end else begin
         u1 = sum1[U_W-1:0];
      end
      if (!cfg.three_point) begin
         pc1_in = PIECE_LINE;
         t1_in  = u1;
         m1_in  = '0;
      end else if (u1 <= U_HALF) begin
         pc1_in = PIECE_LEFT;
         t1_in  = u1;
         m1_in  = M_W'(u1);
      end else begin
         pc1_in = PIECE_RIGHT;
         t1_in  = u1 - U_HALF;
         m1_in  = M_BASE - M_W'(u1 - U_HALF);
      end
   end

   // per-piece coefficients
   always_comb begin
      sfull = $signed({5'b0, cfg.y2}) - $signed({4'b0, cfg.y1, 1'b0})
            + $signed({5'b0, cfg.y0});
      unique case (pc1_ff)
         PIECE_LEFT: begin
            base2_in = cfg.y0;
            dsel     = $signed({5'b0, cfg.y1}) - $signed({5'b0, cfg.y0});
            e18      = (dsel <<< 2) - sfull;
            s2_in    = sfull[13:0];
         end
         PIECE_RIGHT: begin
            base2_in = cfg.y1;
            dsel     = $signed({5'b0, cfg.y2}) - $signed({5'b0, cfg.y1});
            e18      = (dsel <<< 2) - (sfull <<< 1);
            s2_in    = sfull[13:0];
         end
         default: begin
            base2_in = cfg.y0;
            dsel     = $signed({5'b0, cfg.y2}) - $signed({5'b0, cfg.y0});
            e18      = dsel <<< 1;
            s2_in    = '0;
         end
      endcase
      e2_in = e18[15:0];
   end

   always_comb begin
      p_full  = s2_ff * $signed({1'b0, m2_ff});
      p3_in   = p_full[25:0];
      c_full  = e2_ff * C8100;
      c3_in   = c_full[28:0];

      q_full  = $signed({1'b0, t3_ff}) * p3_ff;
      q4_in   = q_full[36:0];

      c_ext   = 38'(c4_ff);
      q_ext   = 38'(q4_ff);
      r5_in   = (c_ext <<< COEF_SHIFT) + q_ext;

      e_full  = $signed({1'b0, t5_ff}) * r5_ff;
      e6_in   = e_full[49:0];

      sum7    = 39'($signed(e6_ff[49:E_SHIFT])) + SUM_BIAS;
      x7_in   = sum7[X_LSB +: 32];

      prod8   = 64'(x7_ff) * 64'(RECIP_M);
      q8_in   = prod8[63:48];

      back9   = 33'(q8_ff) * 33'(DIV_BASE);
      rem9_in = 18'(33'(x8_ff) - back9);

      qz      = 17'(q9_ff) + 17'(rem9_ff >= 18'(DIV_BASE));
      z10     = $signed(19'(base9_ff)) + $signed(19'(qz)) - BIAS_STEPS;
      if (z10 <= 0) begin
         cnt10_in = '0;
      end else if (z10 > $signed(19'(PWM_FULL))) begin
         cnt10_in = PWM_FULL;
      end else begin
         cnt10_in = z10[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= in_valid;
         end
         for (int i = 2; i <= NST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t1_ff  <= t1_in;
         m1_ff  <= m1_in;
         pc1_ff <= pc1_in;
      end
      if (adv[2]) begin
         base2_ff <= base2_in;
         s2_ff    <= s2_in;
         e2_ff    <= e2_in;
         t2_ff    <= t1_ff;
         m2_ff    <= m1_ff;
      end
      if (adv[3]) begin
         p3_ff    <= p3_in;
         c3_ff    <= c3_in;
         base3_ff <= base2_ff;
         t3_ff    <= t2_ff;
      end
      if (adv[4]) begin
         q4_ff    <= q4_in;
         c4_ff    <= c3_ff;
         base4_ff <= base3_ff;
         t4_ff    <= t3_ff;
      end
      if (adv[5]) begin
         r5_ff    <= r5_in;
         base5_ff <= base4_ff;
         t5_ff    <= t4_ff;
      end
      if (adv[6]) begin
         e6_ff    <= e6_in;
         base6_ff <= base5_ff;
      end
      if (adv[7]) begin
         x7_ff    <= x7_in;
         base7_ff <= base6_ff;
      end
      if (adv[8]) begin
         q8_ff    <= q8_in;
         x8_ff    <= x7_ff;
         base8_ff <= base7_ff;
      end
      if (adv[9]) begin
         rem9_ff  <= rem9_in;
         q9_ff    <= q8_ff;
         base9_ff <= base8_ff;
      end
      if (adv[10]) begin
         cnt10_ff <= cnt10_in;
      end
   end

endmodule

>>> rtl/servo_angle_to_pwm_spline.sv
// ----------------------------------------------------------------------------
// servo_angle_to_pwm_spline
// Servo angle to 13-bit PWM on-count, linear or natural cubic spline through
// three calibration counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_ beats carry an angle in 1/16 degree; each gives exactly one rsp_
//   beat with the PWM count (0..4096, 4096 = full on), in order.
//   One beat is taken every cycle while no rsp_ stall backs up the pipe;
//   the 10-stage datapath holds the Horner products, the
//   constant-denominator scaling and the rounding.
//   A stalled rsp_ beat holds; the stall ripples back stage by stage, so
//   bubbles fill first and req_stall rises only when every stage is full.
//   Calibration counts and mode sit in APB registers at 0x0 (mode),
//   0x4 (-90), 0x8 (0) and 0xC (+90); write them only while no beat is in
//   flight. The clamped counts are registered in the cycle after a write.
//   Reset is synchronous: it empties the pipe, holds req_stall high and
//   restores mode 0 with counts 0, 2048 and 4096.
// ----------------------------------------------------------------------------
module servo_angle_to_pwm_spline (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sapwm_pkg::ANGLE_W-1:0]   req_angle_sixteenths,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [sapwm_pkg::COUNT_W-1:0]   rsp_pwm_count,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [sapwm_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic        [sapwm_pkg::DATA_W-1:0]    csr_pwdata,
   output logic        [sapwm_pkg::DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import sapwm_pkg::*;

   logic               mode_ff;
   logic [COUNT_W-1:0] cnt_m90_ff, cnt_zero_ff, cnt_p90_ff;
   sapwm_cfg_type      cfg_ff, cfg_in;
   logic [COUNT_W-1:0] zero_sat, p90_sat, p90_lo;
   logic               csr_wr;
   logic               pipe_stall;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MODE:     csr_prdata = {31'b0, mode_ff};
         REG_CNT_M90:  csr_prdata = 32'(cnt_m90_ff);
         REG_CNT_ZERO: csr_prdata = 32'(cnt_zero_ff);
         REG_CNT_P90:  csr_prdata = 32'(cnt_p90_ff);
      endcase
   end

   always_comb begin
      cfg_in.three_point = mode_ff;
      cfg_in.y0 = (cnt_m90_ff > PWM_FULL) ? PWM_FULL : cnt_m90_ff;
      zero_sat  = (cnt_zero_ff > PWM_FULL) ? PWM_FULL : cnt_zero_ff;
      cfg_in.y1 = (zero_sat < cfg_in.y0) ? cfg_in.y0 : zero_sat;
      p90_lo    = mode_ff ? cfg_in.y1 : cfg_in.y0;
      p90_sat   = (cnt_p90_ff > PWM_FULL) ? PWM_FULL : cnt_p90_ff;
      cfg_in.y2 = (cnt_p90_ff < p90_lo) ? p90_lo : p90_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         cnt_m90_ff     <= '0;
         cnt_zero_ff    <= COUNT_W'(2048);
         cnt_p90_ff     <= PWM_FULL;
         cfg_ff.three_point <= 1'b0;
         cfg_ff.y0      <= '0;
         cfg_ff.y1      <= COUNT_W'(2048);
         cfg_ff.y2      <= PWM_FULL;
      end else begin
         cfg_ff <= cfg_in;
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               REG_MODE:     mode_ff     <= csr_pwdata[0];
               REG_CNT_M90:  cnt_m90_ff  <= csr_pwdata[COUNT_W-1:0];
               REG_CNT_ZERO: cnt_zero_ff <= csr_pwdata[COUNT_W-1:0];
               REG_CNT_P90:  cnt_p90_ff  <= csr_pwdata[COUNT_W-1:0];
            endcase
         end
      end
   end

   sapwm_cfg_type cfg_now;

   // stage one reads the mode register directly
   always_comb begin
      cfg_now             = cfg_ff;
      cfg_now.three_point = mode_ff;
   end

   sapwm_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_now),
      .in_valid  (req_valid),
      .in_stall  (pipe_stall),
      .in_angle  (req_angle_sixteenths),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_count (rsp_pwm_count)
   );

   assign req_stall = reset || pipe_stall;

endmodule

>>> rtl/sapwm_chk.sv
// ----------------------------------------------------------------------------
// sapwm_chk
// Port-level checks for the servo angle to PWM count mapper.
// ----------------------------------------------------------------------------
module sapwm_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [sapwm_pkg::ANGLE_W-1:0]   req_angle_sixteenths,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic        [sapwm_pkg::COUNT_W-1:0]   rsp_pwm_count,
   input logic                                   csr_psel,
   input logic                                   csr_penable,
   input logic                                   csr_pwrite,
   input logic        [sapwm_pkg::ADDR_W-1:0]    csr_paddr,
   input logic        [sapwm_pkg::DATA_W-1:0]    csr_pwdata,
   input logic        [sapwm_pkg::DATA_W-1:0]    csr_prdata,
   input logic                                   csr_pready
);
   import sapwm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pwm_count))
      else $error("stalled rsp beat changed");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pwm_count <= PWM_FULL)
      else $error("pwm count above full scale");

   a_reset_flush: assert property (@(posedge clock)
      reset |-> req_stall ##1 !rsp_valid)
      else $error("reset did not block req or flush rsp");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && (csr_paddr[3:2] != REG_MODE)
      |=> !(csr_psel && !csr_pwrite && (csr_paddr[3:2] == $past(csr_paddr[3:2])))
          || (csr_prdata[COUNT_W-1:0] == $past(csr_pwdata[COUNT_W-1:0])))
      else $error("count register readback mismatch");

endmodule

bind servo_angle_to_pwm_spline sapwm_chk u_sapwm_chk (.*);
